// ===== rtl/cgg_pkg.sv =====
package cgg_pkg;

   localparam int COUNT_W     = 7;
   localparam int HALF_W      = COUNT_W - 1;
   localparam int INDEX_W     = 6;
   localparam int CHAN_W      = 8;
   localparam int COLOR_W     = 24;
   localparam int STEP_W      = 6;
   localparam int DIV_ITER    = CHAN_W;
   localparam int DIV_CNT_W   = $clog2(DIV_ITER);
   localparam int CSR_INDEX_W = 8;
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(2);

   localparam logic [CSR_INDEX_W-1:0] REG_LOW_COLOR  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_MID_COLOR  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_HIGH_COLOR = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_THREE_STOP = CSR_INDEX_W'(3);

   localparam logic [COLOR_W-1:0] LOW_COLOR_RESET  = 24'h000000;
   localparam logic [COLOR_W-1:0] MID_COLOR_RESET  = 24'h7F7F7F;
   localparam logic [COLOR_W-1:0] HIGH_COLOR_RESET = 24'hFFFFFF;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [HALF_W-1:0]  half;
      logic               three;
   } job_type;

   typedef struct packed {
      logic [COLOR_W-1:0] low;
      logic [COLOR_W-1:0] mid;
      logic [COLOR_W-1:0] high;
      logic               three;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_PRE,
      ST_EMIT
   } back_state_type;

   // channel 0 red, 1 green, 2 blue
   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                 input logic [1:0] sel);
      logic [CHAN_W-1:0] res;
      case (sel)
         2'd0: begin
            res = color[23:16];
         end
         2'd1: begin
            res = color[15:8];
         end
         default: begin
            res = color[7:0];
         end
      endcase
      return res;
   endfunction

endpackage

// ===== rtl/cgg_front.sv =====
module cgg_front
   import cgg_pkg::*;
#(
   parameter int MAX_COLORS = 64
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [COUNT_W-1:0] req_count,
   input  logic               three_stop,
   input  logic               queue_full,
   output logic               push,
   output job_type            job
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_COLORS);

   logic [COUNT_W-1:0] count_sat;

   always_comb begin
      if (req_count < MIN_COUNT) begin
         count_sat = MIN_COUNT;
      end else if (req_count > MAX_COUNT) begin
         count_sat = MAX_COUNT;
      end else begin
         count_sat = req_count;
      end
   end

   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;
   assign job.count  = count_sat;
   assign job.half   = count_sat[COUNT_W-1:1];
   assign job.three  = three_stop;

endmodule

// ===== rtl/cgg_queue.sv =====
module cgg_queue
   import cgg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    empty,
   output logic    full
);

   job_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff;
   logic [QPTR_W-1:0]     rd_ptr_ff;
   logic [QPTR_W:0]       fill_ff;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         case ({push, pop})
            2'b10: begin
               fill_ff <= fill_ff + (QPTR_W+1)'(1);
            end
            2'b01: begin
               fill_ff <= fill_ff - (QPTR_W+1)'(1);
            end
            default: begin
               fill_ff <= fill_ff;
            end
         endcase
      end
   end

endmodule

// ===== rtl/cgg_back.sv =====
module cgg_back
   import cgg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_empty,
   input  job_type               q_data,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   back_state_type state_ff, state_in;

   job_type                job_ff;
   logic                   seg_ff;
   logic [INDEX_W-1:0]     idx_ff;
   logic [COUNT_W-1:0]     left_ff;
   logic [STEP_W-1:0]      steps_ff;
   logic [DIV_CNT_W-1:0]   div_cnt_ff;

   logic [CHAN_W-1:0]      val_ff   [3];
   logic                   neg_ff   [3];
   logic [CHAN_W-1:0]      dvd_ff   [3];
   logic [STEP_W-1:0]      prem_ff  [3];
   logic [CHAN_W-1:0]      quo_ff   [3];
   logic [CHAN_W:0]        qstep_ff [3];
   logic [STEP_W-1:0]      rstep_ff [3];
   logic [STEP_W-1:0]      acc_ff   [3];

   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic                   rsp_last_ff;

   logic [COLOR_W-1:0]     seg_a, seg_b;
   logic [COUNT_W-1:0]     steps_w, len_w;
   logic                   last_seg, out_free, do_emit, div_done, rsp_last_in;

   logic [CHAN_W-1:0]      lo_c     [3];
   logic [CHAN_W-1:0]      hi_c     [3];
   logic [CHAN_W:0]        diff_c   [3];
   logic [CHAN_W:0]        mag_c    [3];
   logic [STEP_W:0]        part_c   [3];
   logic                   ge_c     [3];
   logic [STEP_W-1:0]      prem_in  [3];
   logic [CHAN_W-1:0]      quo_in   [3];
   logic [CHAN_W:0]        qstep_in [3];
   logic [STEP_W-1:0]      rstep_in [3];
   logic [STEP_W:0]        rsum_c   [3];
   logic                   wrap_c   [3];
   logic [STEP_W-1:0]      acc_in   [3];
   logic [CHAN_W+1:0]      vsum_c   [3];
   logic [CHAN_W-1:0]      val_in   [3];

   // segment plan
   always_comb begin
      seg_a    = seg_ff ? cfg.mid : cfg.low;
      seg_b    = (job_ff.three && !seg_ff) ? cfg.mid : cfg.high;
      last_seg = !job_ff.three || seg_ff;
      if (!job_ff.three) begin
         steps_w = job_ff.count - COUNT_W'(1);
         len_w   = job_ff.count;
      end else if (!seg_ff) begin
         steps_w = {1'b0, job_ff.half} - COUNT_W'(1);
         len_w   = {1'b0, job_ff.half};
      end else begin
         steps_w = job_ff.count - {1'b0, job_ff.half};
         len_w   = job_ff.count - {1'b0, job_ff.half};
      end
   end

   assign div_done = (div_cnt_ff == DIV_CNT_W'(DIV_ITER - 1));

   // per channel: setup, one divider bit, step finish, ramp advance
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         lo_c[c]   = chan_of(seg_a, 2'(c));
         hi_c[c]   = chan_of(seg_b, 2'(c));
         diff_c[c] = {1'b0, hi_c[c]} - {1'b0, lo_c[c]};
         mag_c[c]  = diff_c[c][CHAN_W] ? (~diff_c[c] + (CHAN_W+1)'(1)) : diff_c[c];

         part_c[c]  = {prem_ff[c], dvd_ff[c][CHAN_W-1]};
         ge_c[c]    = (part_c[c] >= {1'b0, steps_ff});
         prem_in[c] = ge_c[c] ? STEP_W'(part_c[c] - {1'b0, steps_ff})
                              : part_c[c][STEP_W-1:0];
         quo_in[c]  = {quo_ff[c][CHAN_W-2:0], ge_c[c]};

         if (!neg_ff[c]) begin
            qstep_in[c] = {1'b0, quo_in[c]};
            rstep_in[c] = prem_in[c];
         end else if (prem_in[c] == '0) begin
            qstep_in[c] = ~{1'b0, quo_in[c]} + (CHAN_W+1)'(1);
            rstep_in[c] = '0;
         end else begin
            // floor toward minus infinity: -q - 1, remainder folded up
            qstep_in[c] = ~{1'b0, quo_in[c]};
            rstep_in[c] = steps_ff - prem_in[c];
         end

         rsum_c[c] = {1'b0, acc_ff[c]} + {1'b0, rstep_ff[c]};
         wrap_c[c] = (rsum_c[c] >= {1'b0, steps_ff});
         acc_in[c] = wrap_c[c] ? STEP_W'(rsum_c[c] - {1'b0, steps_ff})
                               : rsum_c[c][STEP_W-1:0];
         vsum_c[c] = {2'b00, val_ff[c]} + {qstep_ff[c][CHAN_W], qstep_ff[c]}
                   + {{(CHAN_W+1){1'b0}}, wrap_c[c]};
         val_in[c] = vsum_c[c][CHAN_W-1:0];
      end
   end

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign rsp_last_in = ({1'b0, idx_ff} == (job_ff.count - COUNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      q_pop    = 1'b0;
      do_emit  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = (steps_w == '0) ? ST_EMIT : ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = seg_ff ? ST_PRE : ST_EMIT;
            end
         end
         ST_PRE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               do_emit = 1'b1;
               if (left_ff == COUNT_W'(1)) begin
                  state_in = last_seg ? ST_IDLE : ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               job_ff <= q_data;
               seg_ff <= 1'b0;
               idx_ff <= '0;
            end
         end
         ST_SETUP: begin
            steps_ff   <= steps_w[STEP_W-1:0];
            left_ff    <= len_w;
            div_cnt_ff <= '0;
            for (int c = 0; c < 3; c++) begin
               neg_ff[c]  <= diff_c[c][CHAN_W];
               dvd_ff[c]  <= mag_c[c][CHAN_W-1:0];
               prem_ff[c] <= '0;
               quo_ff[c]  <= '0;
               val_ff[c]  <= (steps_w == '0) ? hi_c[c] : lo_c[c];
            end
         end
         ST_DIV: begin
            div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
            for (int c = 0; c < 3; c++) begin
               prem_ff[c] <= prem_in[c];
               quo_ff[c]  <= quo_in[c];
               dvd_ff[c]  <= {dvd_ff[c][CHAN_W-2:0], 1'b0};
               if (div_done) begin
                  qstep_ff[c] <= qstep_in[c];
                  rstep_ff[c] <= rstep_in[c];
                  acc_ff[c]   <= '0;
               end
            end
         end
         ST_PRE: begin
            for (int c = 0; c < 3; c++) begin
               val_ff[c] <= val_in[c];
               acc_ff[c] <= acc_in[c];
            end
         end
         ST_EMIT: begin
            if (do_emit) begin
               idx_ff  <= idx_ff + INDEX_W'(1);
               left_ff <= left_ff - COUNT_W'(1);
               if (left_ff != COUNT_W'(1)) begin
                  for (int c = 0; c < 3; c++) begin
                     val_ff[c] <= val_in[c];
                     acc_ff[c] <= acc_in[c];
                  end
               end else if (!last_seg) begin
                  seg_ff <= 1'b1;
               end
            end
         end
         default: begin
            seg_ff <= seg_ff;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_emit) begin
         rsp_data_ff <= {2'b00, idx_ff, val_ff[2], val_ff[1], val_ff[0]};
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_emit_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (left_ff != '0))
      else $error("emit state with no colors left in segment");

   a_emit_index: assert property (@(posedge clock) disable iff (reset)
      do_emit |-> ({1'b0, idx_ff} < job_ff.count))
      else $error("color index beyond run length");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (do_emit && rsp_last_in) |=> (state_ff == ST_IDLE))
      else $error("run did not end after final color");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && (steps_ff != '0)) |->
         ((acc_ff[0] < steps_ff) && (acc_ff[1] < steps_ff) && (acc_ff[2] < steps_ff)))
      else $error("ramp remainder out of range");

endmodule

// ===== rtl/color_gradient_generator_core.sv =====
// channel   dir  handshake                  payload
// req       in   req_tvalid / req_tready    req_tdata: color_count
// rsp       out  rsp_tvalid / rsp_tready    rsp_tdata: red, green, blue, color_index; rsp_tlast
// csr       in   csr_valid / csr_ready      csr_index, csr_data
//
// n colors (after saturation), two-stop: a pop, a setup state, a bit-serial divider for the
// per-color step, then one color per cycle while the output is not stalled; three-stop adds a
// second setup, divider and pre-step, and no first divider when the first segment is one color
// reset is synchronous and active high; it clears the queue, the sequencer, the output
// register and loads the color registers with their reset values
// a stalled result holds in the output register; the two-entry queue keeps taking requests until it is full
module color_gradient_generator_core
   import cgg_pkg::*;
#(
   parameter int MAX_COLORS = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [6:0] color_count
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
                                               // [29:24] color_index
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]     csr_data
);

   // configuration registers
   logic [COLOR_W-1:0] low_color_ff;
   logic [COLOR_W-1:0] mid_color_ff;
   logic [COLOR_W-1:0] high_color_ff;
   logic               three_stop_ff;

   cfg_type cfg;

   // front to queue to back
   logic    push, q_pop, q_empty, q_full;
   job_type push_job, q_job;

   // writes always taken, unknown indexes dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_color_ff  <= LOW_COLOR_RESET;
         mid_color_ff  <= MID_COLOR_RESET;
         high_color_ff <= HIGH_COLOR_RESET;
         three_stop_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LOW_COLOR: begin
               low_color_ff <= csr_data;
            end
            REG_MID_COLOR: begin
               mid_color_ff <= csr_data;
            end
            REG_HIGH_COLOR: begin
               high_color_ff <= csr_data;
            end
            REG_THREE_STOP: begin
               three_stop_ff <= csr_data[0];
            end
            default: begin
               three_stop_ff <= three_stop_ff;
            end
         endcase
      end
   end

   assign cfg.low   = low_color_ff;
   assign cfg.mid   = mid_color_ff;
   assign cfg.high  = high_color_ff;
   assign cfg.three = three_stop_ff;

   // front: count saturation and segment split
   cgg_front #(
      .MAX_COLORS (MAX_COLORS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_count  (req_tdata[COUNT_W-1:0]),
      .three_stop (three_stop_ff),
      .queue_full (q_full),
      .push       (push),
      .job        (push_job)
   );

   // short queue of pending runs
   cgg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (q_pop),
      .pop_data  (q_job),
      .empty     (q_empty),
      .full      (q_full)
   );

   // back: step division and color ramp
   cgg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_empty    (q_empty),
      .q_data     (q_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
